[hw/rtl/sprq_pkg.sv]
// Shared types and codes for the stable priority request queue.
package sprq_pkg;

	// One stored request.
	typedef struct packed {
		logic [15:0] client_id;
		logic [15:0] socket_handle;
		logic [3:0]  row;
		logic [3:0]  col;
		logic [3:0]  cell_value;
		logic [7:0]  priority_req;
	} entry_t;

	// Operation codes carried in the input tuser.
	localparam logic OP_ENQUEUE = 1'b0;
	localparam logic OP_DEQUEUE = 1'b1;

	// Result status codes carried in the output tuser.
	localparam logic [1:0] ST_ENQUEUED = 2'd0;
	localparam logic [1:0] ST_DEQUEUED = 2'd1;
	localparam logic [1:0] ST_EMPTY    = 2'd2;
	localparam logic [1:0] ST_FULL     = 2'd3;

	// Reset value of the start threshold register.
	localparam logic [4:0] THRESHOLD_RESET = 5'd6;

	// Per-cycle command broadcast to every cell of the chain.
	typedef struct packed {
		logic insert;
		logic remove;
	} cell_ctrl_t;

endpackage

[hw/rtl/sprq_cell.sv]
// One slot of the sorted chain: keeps, shifts, or captures a request.
module sprq_cell (
	input  logic                clk,
	input  sprq_pkg::cell_ctrl_t ctrl,
	input  logic                occupied,
	input  logic                left_after,
	input  sprq_pkg::entry_t    new_entry,
	input  sprq_pkg::entry_t    left_entry,
	input  sprq_pkg::entry_t    right_entry,
	output logic                after,
	output sprq_pkg::entry_t    entry_q
);
	import sprq_pkg::*;

	// The new request goes behind this slot when the slot holds an equal or higher priority.
	assign after = occupied && (entry_q.priority_req >= new_entry.priority_req);

	// On insert, slots ahead keep, the insertion slot captures, slots behind shift back.
	// On remove, every slot but the tail takes the request behind it; the tail keeps its own.
	always_ff @(posedge clk) begin
		if (ctrl.insert) begin
			if (!after) begin
				if (left_after) begin
					entry_q <= new_entry;
				end else begin
					entry_q <= left_entry;
				end
			end
		end else if (ctrl.remove) begin
			entry_q <= right_entry;
		end
	end

endmodule

[hw/rtl/stable_priority_request_queue.sv]
// Top level of the stable priority request queue built as a chain of sorted cells.
//
// Usage: requests enter on the s_axis channel. tuser selects the operation
// (enqueue or dequeue) and tdata carries the request. Each accepted transfer
// produces exactly one result transfer on m_axis: a status code in tuser and,
// in tdata, the dequeued request (zero unless dequeued), the occupancy after
// the operation and the sticky start flag.
// The result appears on m_axis in the cycle after the input transfer.
// Throughput is one item per cycle: every cell compares its own priority
// with the incoming one and shifts to its neighbor in the same cycle, so the
// single result register is the only limit. A new item is taken while the
// previous result waits, as long as the receiver takes that result in the
// same cycle; if the receiver stalls, s_axis_tready drops until it resumes.
// Higher priority leaves first; equal priorities leave in arrival order.
// Reset clears the entry count, the start flag and the result valid flag and
// loads the start threshold with 6. Slot contents are not cleared; only
// occupied slots are ever read. cfg_we writes the threshold register.
module stable_priority_request_queue #(
	parameter int DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [4:0]  cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// Fields from bit 0: client_id, socket_handle, row, col, cell_value, priority_req, zero pad.
	input  logic [55:0] s_axis_tdata,
	// Fields from bit 0: operation.
	input  logic        s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// Fields from bit 0: out_client_id, out_socket_handle, out_row, out_col,
	// out_cell_value, out_priority, occupancy, start_flag, zero pad.
	output logic [63:0] m_axis_tdata,
	// Fields from bit 0: status.
	output logic [1:0]  m_axis_tuser
);
	import sprq_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);

	logic [CW-1:0]  count_q;
	logic           started_q;
	logic [4:0]     threshold_q;
	logic           out_valid_q;
	logic [63:0]    out_data_q;
	logic [1:0]     out_status_q;

	logic           accept;
	logic           is_full;
	logic           is_empty;
	cell_ctrl_t     ctrl;
	entry_t         new_entry;
	entry_t         cell_entry [DEPTH];
	logic           cell_after [DEPTH];
	logic [CW-1:0]  next_count;
	logic [CW+4:0]  count_ext;
	logic [CW+4:0]  threshold_ext;
	logic           next_started;
	logic [1:0]     next_status;
	entry_t         head_out;

	// Handshake: a new transfer is taken when the result register is free or draining.
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;

	// Unpack the incoming request.
	assign new_entry.client_id     = s_axis_tdata[15:0];
	assign new_entry.socket_handle = s_axis_tdata[31:16];
	assign new_entry.row           = s_axis_tdata[35:32];
	assign new_entry.col           = s_axis_tdata[39:36];
	assign new_entry.cell_value    = s_axis_tdata[43:40];
	assign new_entry.priority_req  = s_axis_tdata[51:44];

	assign is_full  = (count_q == CW'(DEPTH));
	assign is_empty = (count_q == '0);

	// Commands for the chain.
	assign ctrl.insert = accept && (s_axis_tuser == OP_ENQUEUE) && !is_full;
	assign ctrl.remove = accept && (s_axis_tuser == OP_DEQUEUE) && !is_empty;

	// The chain of cells, head at index zero.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic   occ;
		logic   left_after;
		entry_t left_entry;
		entry_t right_entry;

		assign occ = (CW'(i) < count_q);

		if (i == 0) begin : g_head
			assign left_after = 1'b1;
			assign left_entry = new_entry;
		end else begin : g_body
			assign left_after = cell_after[i-1];
			assign left_entry = cell_entry[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign right_entry = cell_entry[i];
		end else begin : g_inner
			assign right_entry = cell_entry[i+1];
		end

		sprq_cell u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.occupied    (occ),
			.left_after  (left_after),
			.new_entry   (new_entry),
			.left_entry  (left_entry),
			.right_entry (right_entry),
			.after       (cell_after[i]),
			.entry_q     (cell_entry[i])
		);
	end

	// Next count, start flag and status for the accepted transfer.
	always_comb begin
		next_count   = count_q;
		next_status  = ST_ENQUEUED;
		head_out     = '0;
		if (s_axis_tuser == OP_ENQUEUE) begin
			if (is_full) begin
				next_status = ST_FULL;
			end else begin
				next_count  = count_q + CW'(1);
				next_status = ST_ENQUEUED;
			end
		end else begin
			if (is_empty) begin
				next_status = ST_EMPTY;
			end else begin
				next_count  = count_q - CW'(1);
				next_status = ST_DEQUEUED;
				head_out    = cell_entry[0];
			end
		end
	end

	assign count_ext     = {5'd0, next_count};
	assign threshold_ext = {{CW{1'b0}}, threshold_q};
	assign next_started  = started_q || (ctrl.insert && (count_ext == threshold_ext));

	// Control state: count, flag and threshold register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			started_q   <= 1'b0;
			threshold_q <= THRESHOLD_RESET;
		end else begin
			if (accept) begin
				count_q   <= next_count;
				started_q <= next_started;
			end
			if (cfg_we) begin
				threshold_q <= cfg_wdata;
			end
		end
	end

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload register.
	always_ff @(posedge clk) begin
		if (accept) begin
			out_status_q <= next_status;
			out_data_q   <= {6'd0, next_started, count_ext[4:0],
				head_out.priority_req, head_out.cell_value, head_out.col,
				head_out.row, head_out.socket_handle, head_out.client_id};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_status_q;

endmodule
